FILE: rtl/pwm_period_duty_capture_assert.svh
// assertion macros for the capture block checker pdc_checker
// no dependencies; clk_i and rst_ni must exist in the using scope
`ifndef PWM_PERIOD_DUTY_CAPTURE_ASSERT_SVH
`define PWM_PERIOD_DUTY_CAPTURE_ASSERT_SVH

// same-cycle implication
`define PDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pdc assertion failed");

// next-cycle implication
`define PDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pdc assertion failed");

`endif

FILE: rtl/pdc_pkg.sv
// types and constants of the pwm period and duty capture block
// no dependencies
package pdc_pkg;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  channel;
    logic        pin_level;
    logic [31:0] timestamp;
  } pdc_in_t;

  typedef struct packed {
    logic [2:0]  out_channel;
    logic        captured;
    logic [31:0] period_ticks;
    logic [6:0]  duty_percent;
    logic [7:0]  duty_byte;
  } pdc_out_t;

  localparam logic REQ_EDGE   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [1:0] STAGE_WAIT_RISE  = 2'd0;
  localparam logic [1:0] STAGE_WAIT_FALL  = 2'd1;
  localparam logic [1:0] STAGE_WAIT_RISE2 = 2'd2;
  localparam logic [1:0] STAGE_HELD       = 2'd3;

  localparam logic [6:0] DUTY_FULL = 7'd100;
  localparam logic [6:0] DUTY_NONE = 7'd0;

  // floor(x / 100) as (x * 5243) >> 19, exact for x up to 25500
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  function automatic logic [7:0] duty_to_byte(input logic [6:0] duty);
    logic [14:0] scaled;
    logic [27:0] prod;
    scaled = {duty, 8'b0} - 15'(duty);
    prod   = 28'(scaled) * 28'(RECIP_100);
    return prod[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

endpackage

FILE: rtl/pdc_ram.sv
// generic single-port-write, single-port-read memory with registered read
// no dependencies
module pdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pwm_period_duty_capture.sv
// pwm period and duty capture; per-channel state lives in pdc_ram, uses pdc_pkg
// edge event: state is written back in the cycle after it is accepted, then the block is idle again
// sample with a held capture: S_READ, S_PREP, the 7-step restoring divider for the rounded
// duty in S_DIV, then S_FIN loads the output register once it is free; without a capture: S_READ, then S_FIN
// one item at a time; input ready only while idle, output register decouples the sink
// reset clears control and the per-channel valid flags; no memory sweep needed
module pwm_period_duty_capture
  import pdc_pkg::*;
#(
  parameter int unsigned CHANNELS   = 5,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pdc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pdc_out_t out_data_o
);

  localparam int unsigned TW    = TIME_WIDTH;
  localparam int unsigned CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned NW    = TW + 8;
  localparam logic [5:0]  CH_LIM = 6'(CHANNELS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  typedef struct packed {
    logic [1:0]    stage;
    logic [TW-1:0] mark;
    logic [TW-1:0] high;
    logic [TW-1:0] period;
  } entry_t;

  logic [2:0]          state_q, state_d;
  pdc_in_t             item_q;
  logic [CH_AW-1:0]    addr_q;
  logic [CHANNELS-1:0] valid_q;
  logic [TW-1:0]       period_q, period_d;
  logic [TW-1:0]       low_q, low_d;
  logic [NW-1:0]       rem_q, rem_d;
  logic [6:0]          quo_q, quo_d;
  logic [2:0]          bit_q, bit_d;
  logic                cap_q, cap_d;
  pdc_out_t            out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic             accept;
  logic             in_range;
  logic [7:0]       ch_ext;
  logic [CH_AW-1:0] raddr;
  logic [$bits(entry_t)-1:0] rdata;
  entry_t           entry, entry_new;
  logic [63:0]      ts_ext;
  logic [TW-1:0]    ts_w;
  logic [TW-1:0]    diff;
  logic             ts_gt;
  logic             ram_we;
  logic [NW-1:0]    trial;
  logic [63:0]      period_ext;
  logic [6:0]       duty_fin;
  logic             out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign ch_ext     = 8'(in_data_i.channel);
  assign raddr      = ch_ext[CH_AW-1:0];
  assign in_range   = 6'(in_data_i.channel) < CH_LIM;

  assign ram_we = (state_q == S_READ);

  pdc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CHANNELS)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i(entry_new),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign entry  = valid_q[addr_q] ? entry_t'(rdata) : '0;
  assign ts_ext = 64'(item_q.timestamp);
  assign ts_w   = ts_ext[TW-1:0];
  assign diff   = ts_w - entry.mark;
  assign ts_gt  = ts_w > entry.mark;

  assign trial      = NW'({period_q, 1'b0}) << bit_q;
  assign period_ext = 64'(period_q);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    if (cap_q) begin
      duty_fin = quo_q;
    end else if (item_q.pin_level) begin
      duty_fin = DUTY_NONE;
    end else begin
      duty_fin = DUTY_FULL;
    end
  end

  always_comb begin
    state_d     = state_q;
    entry_new   = entry;
    period_d    = period_q;
    low_d       = low_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    bit_d       = bit_q;
    cap_d       = cap_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept && in_range) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (item_q.req_type == REQ_EDGE) begin
          case (entry.stage)
            STAGE_WAIT_RISE: begin
              if (item_q.pin_level) begin
                entry_new.stage  = STAGE_WAIT_FALL;
                entry_new.mark   = ts_w;
                entry_new.high   = '0;
                entry_new.period = '0;
              end
            end
            STAGE_WAIT_FALL: begin
              if (!item_q.pin_level && ts_gt) begin
                entry_new.stage = STAGE_WAIT_RISE2;
                entry_new.high  = diff;
              end else begin
                entry_new.stage = STAGE_WAIT_RISE;
              end
            end
            STAGE_WAIT_RISE2: begin
              if (item_q.pin_level && ts_gt) begin
                entry_new.stage  = STAGE_HELD;
                entry_new.period = diff;
              end else begin
                entry_new.stage = STAGE_WAIT_RISE;
              end
            end
            default: begin
            end
          endcase
          state_d = S_IDLE;
        end else if (entry.stage == STAGE_HELD && entry.period != '0) begin
          entry_new.stage = STAGE_WAIT_RISE;
          period_d = entry.period;
          low_d    = (entry.period >= entry.high) ? entry.period - entry.high : '0;
          cap_d    = 1'b1;
          state_d  = S_PREP;
        end else begin
          entry_new.period = '0;
          cap_d   = 1'b0;
          state_d = S_FIN;
        end
      end
      S_PREP: begin
        // 200 * low + period, for round half up of 100 * low / period
        rem_d   = (NW'(low_q) << 7) + (NW'(low_q) << 6) + (NW'(low_q) << 3)
                  + NW'(period_q);
        quo_d   = '0;
        bit_d   = 3'd6;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (rem_q >= trial) begin
          rem_d        = rem_q - trial;
          quo_d[bit_q] = 1'b1;
        end
        if (bit_q == 3'd0) begin
          state_d = S_FIN;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_d.out_channel  = item_q.channel;
          out_d.captured     = cap_q;
          out_d.period_ticks = cap_q ? period_ext[31:0] : '0;
          out_d.duty_percent = duty_fin;
          out_d.duty_byte    = duty_to_byte(duty_fin);
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      cap_q       <= 1'b0;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cap_q       <= cap_d;
      bit_q       <= bit_d;
      if (ram_we) begin
        valid_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      addr_q <= raddr;
    end
    period_q <= period_d;
    low_q    <= low_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/pdc_checker.sv
// port-level checker for the pwm capture block, bound to the top level
// depends on pdc_pkg and pwm_period_duty_capture_assert.svh
`include "pwm_period_duty_capture_assert.svh"

module pdc_checker
  import pdc_pkg::*;
#(
  parameter int unsigned CHANNELS = 5
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input pdc_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input pdc_out_t out_data_o
);

  localparam logic [5:0] CH_LIM = 6'(CHANNELS);

  logic in_xfer;
  logic in_ch_ok;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign in_ch_ok = 6'(in_data_i.channel) < CH_LIM;

  // stalled result holds
  `PDC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_data_o))

  // an edge transfer never produces a result
  `PDC_ASSERT_NEXT(a_edge_silent, in_xfer && in_data_i.req_type == REQ_EDGE,
                   !$rose(out_valid_o))

  // a sample in range keeps the input closed while it is worked on
  `PDC_ASSERT_NEXT(a_sample_busy, in_xfer && in_data_i.req_type == REQ_SAMPLE && in_ch_ok,
                   !in_ready_o)

  // without a capture the result is the pin fallback
  `PDC_ASSERT_NOW(a_no_capture, out_valid_o && !out_data_o.captured,
                  out_data_o.period_ticks == '0 &&
                  ((out_data_o.duty_percent == DUTY_NONE && out_data_o.duty_byte == 8'd0) ||
                   (out_data_o.duty_percent == DUTY_FULL && out_data_o.duty_byte == 8'd255)))

  // duty stays in range
  `PDC_ASSERT_NOW(a_duty_range, out_valid_o, out_data_o.duty_percent <= DUTY_FULL)

endmodule

bind pwm_period_duty_capture pdc_checker #(.CHANNELS(CHANNELS)) u_pdc_checker (.*);

FILE: sim/capture_checker.sv
`timescale 1ns / 100ps
// capture_checker: watches both transfer channels of pwm_period_duty_capture,
// predicts every sample result and compares it field by field; uses pdc_pkg
module capture_checker
  import pdc_pkg::*;
#(
  parameter int unsigned CHANNELS = 5
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  pdc_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  pdc_out_t out_data_i,
  output int       errors_o,
  output int       pending_o
);

  logic [1:0]  stage_q  [CHANNELS];
  logic [31:0] mark_q   [CHANNELS];
  logic [31:0] high_q   [CHANNELS];
  logic [31:0] period_q [CHANNELS];
  pdc_out_t    sample_results_q [$];
  int          mismatches = 0;

  task automatic advance_capture(input pdc_in_t item);
    int unsigned c;
    pdc_out_t    res;
    logic [31:0] low;
    logic [63:0] scaled;
    logic [6:0]  duty;
    if (item.channel < CHANNELS) begin
      c = item.channel;
      if (item.req_type == REQ_EDGE) begin
        case (stage_q[c])
          STAGE_WAIT_RISE: begin
            if (item.pin_level) begin
              mark_q[c]   = item.timestamp;
              period_q[c] = '0;
              high_q[c]   = '0;
              stage_q[c]  = STAGE_WAIT_FALL;
            end
          end
          STAGE_WAIT_FALL: begin
            if (!item.pin_level && item.timestamp > mark_q[c]) begin
              high_q[c]  = item.timestamp - mark_q[c];
              stage_q[c] = STAGE_WAIT_RISE2;
            end else begin
              stage_q[c] = STAGE_WAIT_RISE;
            end
          end
          STAGE_WAIT_RISE2: begin
            if (item.pin_level && item.timestamp > mark_q[c]) begin
              period_q[c] = item.timestamp - mark_q[c];
              stage_q[c]  = STAGE_HELD;
            end else begin
              stage_q[c] = STAGE_WAIT_RISE;
            end
          end
          default: ;
        endcase
      end else begin
        res.out_channel = item.channel;
        if (stage_q[c] == STAGE_HELD && period_q[c] != '0) begin
          // low share, rounded half up; low time saturates at zero
          low    = (period_q[c] >= high_q[c]) ? period_q[c] - high_q[c] : '0;
          scaled = 64'(low) * 64'd200 + 64'(period_q[c]);
          duty   = 7'(scaled / (64'(period_q[c]) * 64'd2));
          res.captured     = 1'b1;
          res.period_ticks = period_q[c];
          stage_q[c]       = STAGE_WAIT_RISE;
        end else begin
          period_q[c]      = '0;
          duty             = item.pin_level ? DUTY_NONE : DUTY_FULL;
          res.captured     = 1'b0;
          res.period_ticks = '0;
        end
        res.duty_percent = duty;
        res.duty_byte    = 8'((32'(duty) * 32'd255) / 32'd100);
        sample_results_q.push_back(res);
      end
    end
  endtask

  task automatic check_sample(input pdc_out_t got);
    pdc_out_t want;
    if (sample_results_q.size() == 0) begin
      $error("unexpected sample result on channel %0d", got.out_channel);
      mismatches++;
    end else begin
      want = sample_results_q.pop_front();
      if (got.out_channel !== want.out_channel) begin
        $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
        mismatches++;
      end
      if (got.captured !== want.captured) begin
        $error("captured: expected %0d, got %0d", want.captured, got.captured);
        mismatches++;
      end
      if (got.period_ticks !== want.period_ticks) begin
        $error("period_ticks: expected %0d, got %0d", want.period_ticks, got.period_ticks);
        mismatches++;
      end
      if (got.duty_percent !== want.duty_percent) begin
        $error("duty_percent: expected %0d, got %0d", want.duty_percent, got.duty_percent);
        mismatches++;
      end
      if (got.duty_byte !== want.duty_byte) begin
        $error("duty_byte: expected %0d, got %0d", want.duty_byte, got.duty_byte);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        stage_q[c]  = STAGE_WAIT_RISE;
        mark_q[c]   = '0;
        high_q[c]   = '0;
        period_q[c] = '0;
      end
      sample_results_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) advance_capture(in_data_i);
      if (out_valid_i && out_ready_i) check_sample(out_data_i);
    end
    errors_o  <= mismatches;
    pending_o <= sample_results_q.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for pwm_period_duty_capture with random gaps on both sides
// depends on pdc_pkg, the block and capture_checker
module tb;
  import pdc_pkg::*;

  localparam int unsigned NUM_CH       = 5;
  localparam int          RANDOM_ITEMS = 1630;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 30;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  pdc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pdc_out_t out_data;
  int       errors;
  int       pending;
  int       idle_cycles = 0;
  logic     src_quiet  = 1'b0;
  logic     sink_quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  pwm_period_duty_capture #(
    .CHANNELS  (NUM_CH),
    .TIME_WIDTH(32)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  capture_checker #(
    .CHANNELS(NUM_CH)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall after each transfer
  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    out_ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(out_valid && out_ready));
      if (taken % 64 == 0) sink_quiet = ($urandom_range(3, 0) == 0);
      taken++;
      stall = sink_quiet ? 0 : $urandom_range(19, 0);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send(input pdc_in_t item);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(19, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drive_event(input logic req, input logic [2:0] ch, input logic lvl,
                             input logic [31:0] ts);
    pdc_in_t item;
    item.req_type  = req;
    item.channel   = ch;
    item.pin_level = lvl;
    item.timestamp = ts;
    send(item);
  endtask

  initial begin
    logic [1:0]  seq_phase  [NUM_CH];
    logic [31:0] seq_mark   [NUM_CH];
    logic [31:0] seq_high   [NUM_CH];
    logic [31:0] seq_period [NUM_CH];
    int unsigned r;
    int unsigned c;
    logic [31:0] span;
    logic [31:0] hi;
    logic [31:0] base;

    for (int k = 0; k < NUM_CH; k++) begin
      seq_phase[k]  = 2'd0;
      seq_mark[k]   = '0;
      seq_high[k]   = '0;
      seq_period[k] = '0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // samples with nothing captured, both pin levels
    drive_event(REQ_SAMPLE, 3'd0, 1'b1, 32'h0000_0000);
    drive_event(REQ_SAMPLE, 3'd1, 1'b0, 32'hFFFF_FFFF);
    // low pin while waiting for a rise
    drive_event(REQ_EDGE, 3'd0, 1'b0, 32'd50);
    // fall not later than the mark
    drive_event(REQ_EDGE, 3'd0, 1'b1, 32'd0);
    drive_event(REQ_EDGE, 3'd0, 1'b0, 32'd0);
    // plain capture, then an edge while held
    drive_event(REQ_EDGE, 3'd0, 1'b1, 32'd100);
    drive_event(REQ_EDGE, 3'd0, 1'b0, 32'd130);
    drive_event(REQ_EDGE, 3'd0, 1'b1, 32'd200);
    drive_event(REQ_EDGE, 3'd0, 1'b0, 32'd500);
    drive_event(REQ_SAMPLE, 3'd0, 1'b0, 32'd0);
    // wrong level while waiting for the fall
    drive_event(REQ_EDGE, 3'd1, 1'b1, 32'd10);
    drive_event(REQ_EDGE, 3'd1, 1'b1, 32'd20);
    // half percent rounds up
    drive_event(REQ_EDGE, 3'd1, 1'b1, 32'd1000);
    drive_event(REQ_EDGE, 3'd1, 1'b0, 32'd1199);
    drive_event(REQ_EDGE, 3'd1, 1'b1, 32'd1200);
    drive_event(REQ_SAMPLE, 3'd1, 1'b1, 32'd0);
    // largest period
    drive_event(REQ_EDGE, 3'd2, 1'b1, 32'h0000_0000);
    drive_event(REQ_EDGE, 3'd2, 1'b0, 32'h0000_0001);
    drive_event(REQ_EDGE, 3'd2, 1'b1, 32'hFFFF_FFFF);
    drive_event(REQ_SAMPLE, 3'd2, 1'b1, 32'hFFFF_FFFF);
    // high time longer than the period
    drive_event(REQ_EDGE, 3'd3, 1'b1, 32'd10);
    drive_event(REQ_EDGE, 3'd3, 1'b0, 32'd100);
    drive_event(REQ_EDGE, 3'd3, 1'b1, 32'd50);
    drive_event(REQ_SAMPLE, 3'd3, 1'b0, 32'd0);
    // second rise wraps below the mark
    drive_event(REQ_EDGE, 3'd4, 1'b1, 32'hFFFF_FFF0);
    drive_event(REQ_EDGE, 3'd4, 1'b0, 32'hFFFF_FFFF);
    drive_event(REQ_EDGE, 3'd4, 1'b1, 32'd5);
    drive_event(REQ_SAMPLE, 3'd4, 1'b0, 32'd7);
    // channels beyond the last one
    drive_event(REQ_EDGE, 3'd7, 1'b1, 32'h8000_0000);
    drive_event(REQ_SAMPLE, 3'd5, 1'b0, 32'h7FFF_FFFF);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 128 == 0) src_quiet = ($urandom_range(3, 0) == 0);
      r = $urandom_range(99, 0);
      if (r < 65) begin
        // rise, fall, rise, sample on one channel, interleaved with others
        c = $urandom_range(NUM_CH - 1, 0);
        case (seq_phase[c])
          2'd0: begin
            if ($urandom_range(1, 0) == 1) span = $urandom_range(300, 2);
            else span = $urandom_range(32'hFFFF_FF00, 2);
            if ($urandom_range(19, 0) == 0) hi = span + $urandom_range(50, 1);
            else hi = $urandom_range(span - 1, 1);
            base = $urandom_range(32'hFFFF_FFFF - span - 32'd64, 0);
            seq_mark[c]   = base;
            seq_high[c]   = hi;
            seq_period[c] = span;
            drive_event(REQ_EDGE, 3'(c), 1'b1, base);
          end
          2'd1: drive_event(REQ_EDGE, 3'(c), 1'b0, seq_mark[c] + seq_high[c]);
          2'd2: drive_event(REQ_EDGE, 3'(c), 1'b1, seq_mark[c] + seq_period[c]);
          default: drive_event(REQ_SAMPLE, 3'(c), 1'($urandom_range(1, 0)), $urandom());
        endcase
        seq_phase[c] = seq_phase[c] + 2'd1;
      end else if (r < 80) begin
        drive_event(REQ_SAMPLE, 3'($urandom_range(7, 0)), 1'($urandom_range(1, 0)),
                    $urandom());
      end else begin
        drive_event(1'($urandom_range(1, 0)), 3'($urandom_range(7, 0)),
                    1'($urandom_range(1, 0)), $urandom());
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
